// ===== design/pvs_pkg.sv =====
// Package for the page victim selector: field widths, operation and mode codes,
// default sizes. Used by the channel interfaces and the top level; no dependencies.
package pvs_pkg;

  // Default sizes handed to the top level parameters
  localparam int FRAME_COUNT_DEF = 32;
  localparam int AGE_BITS_DEF    = 8;

  // Fixed field widths of the item channels and the mode register
  localparam int OP_W     = 2;
  localparam int FRAME_W  = 5;
  localparam int RANDOM_W = 32;
  localparam int MODE_W   = 2;

  // Bits that select one coin out of the random word
  localparam int COIN_SEL_W = $clog2(RANDOM_W);

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_SELECT    = 2'd0,
    OP_AGE_TICK  = 2'd1,
    OP_MARK_REF  = 2'd2,
    OP_SET_FLAGS = 2'd3
  } op_t;

  // Replacement modes; the fourth code falls back to random
  localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLOCK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LRU    = 2'd2;

endpackage

// ===== design/pvs_if.sv =====
// Valid/ready channel interfaces of the page victim selector: command items in,
// victim items out. Depends on pvs_pkg for the field widths.
interface pvs_in_if;
  logic                          valid;
  logic                          ready;
  logic [pvs_pkg::OP_W-1:0]      operation;
  logic [pvs_pkg::FRAME_W-1:0]   frame_index;
  logic                          mapped_flag;
  logic                          protected_flag;
  logic [pvs_pkg::RANDOM_W-1:0]  random_bits;

  modport source (output valid, operation, frame_index, mapped_flag, protected_flag,
                  random_bits, input ready);
  modport sink   (input valid, operation, frame_index, mapped_flag, protected_flag,
                  random_bits, output ready);
endinterface

interface pvs_out_if;
  logic                          valid;
  logic                          ready;
  logic [pvs_pkg::FRAME_W-1:0]   victim_frame;
  logic                          victim_was_mapped;
  logic                          out_of_memory;

  modport source (output valid, victim_frame, victim_was_mapped, out_of_memory,
                  input ready);
  modport sink   (input valid, victim_frame, victim_was_mapped, out_of_memory,
                  output ready);
endinterface

// ===== design/pvs_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pvs_age_alu.sv =====
// Shared per-frame aging unit: shift-in of the referenced bit for the aging tick
// and the running-minimum compare for LRU selection. No package use.
module pvs_age_alu #(
  parameter int AGE_BITS = 8
) (
  input  logic [AGE_BITS-1:0] age_in,
  input  logic                referenced,
  input  logic [AGE_BITS-1:0] best_age,
  input  logic                best_valid,
  output logic [AGE_BITS-1:0] age_next,
  output logic                is_lower
);

  // Shift right, referenced bit becomes the new top bit
  assign age_next = {referenced, age_in[AGE_BITS-1:1]};

  // Strictly lower than the best so far; the first candidate always wins
  assign is_lower = !best_valid || (age_in < best_age);

endmodule

// ===== design/page_victim_selector_unit.sv =====
// Page victim selector top level: frame flags, clock hand, scan sequencer and
// output register. Depends on pvs_pkg, pvs_if, pvs_ram and pvs_age_alu.
//
// One item at a time; ready is high only while the sequencer is idle. Mark
// referenced and set flags are done in idle. An aging tick walks all frames,
// one per cycle through the aging RAM read port. Select victim scans the
// frames the same way, stopping early at a free frame; in clock mode it adds
// a second-chance sweep, then loads the result register once that is free.
// Scan and aging steps go through the one aging RAM port and the shared
// shift/compare unit. The result register lets the next item enter while the
// previous result waits. The user must write the replacement mode register
// only while the block is idle; the block itself does not enforce this.
module page_victim_selector_unit #(
  parameter int FRAME_COUNT = pvs_pkg::FRAME_COUNT_DEF,
  parameter int AGE_BITS    = pvs_pkg::AGE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  pvs_in_if.sink                     cmd,
  pvs_out_if.source                  rsp,
  input  logic                       cfg_wr_en,
  input  logic [pvs_pkg::MODE_W-1:0] cfg_wr_data
);

  localparam int IDX_W  = $clog2(FRAME_COUNT);
  localparam int WIDE_W = IDX_W + 6;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_AGE   = 5'b00100,
    S_CLOCK = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state;

  // Frame state
  logic [FRAME_COUNT-1:0] prot;
  logic [FRAME_COUNT-1:0] mapped;
  logic [FRAME_COUNT-1:0] refd;
  logic [FRAME_COUNT-1:0] age_valid;
  logic [pvs_pkg::MODE_W-1:0] mode;
  logic [IDX_W-1:0] hand;

  // Sequencer
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] idx_d;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] pos_next;
  logic             iss;
  logic             eval_v;
  logic [pvs_pkg::RANDOM_W-1:0] coins;

  // Scan trackers
  logic             any_found;
  logic             coin_found;
  logic             lru_found;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] coin_idx;
  logic [IDX_W-1:0] best_idx;
  logic [AGE_BITS-1:0] low;

  // Chosen victim
  logic [IDX_W-1:0] vict;
  logic             vict_oom;
  logic [WIDE_W-1:0] vict_wide;

  // Output register
  logic                        out_valid;
  logic [pvs_pkg::FRAME_W-1:0] out_frame;
  logic                        out_was_mapped;
  logic                        out_oom;

  // Per-frame evaluation
  logic [AGE_BITS-1:0] ram_q;
  logic [AGE_BITS-1:0] age_cur;
  logic [AGE_BITS-1:0] age_aged;
  logic                age_lower;
  logic                age_we;
  logic [WIDE_W-1:0]   idx_wide;
  logic                unprot;
  logic                is_free;
  logic                coin;
  logic                any_n;
  logic                coin_found_n;
  logic                take_lru;
  logic                lru_found_n;
  logic [IDX_W-1:0]    last_n;
  logic [IDX_W-1:0]    coin_idx_n;
  logic [IDX_W-1:0]    best_n;
  logic [AGE_BITS-1:0] low_n;
  logic [IDX_W-1:0]    rand_pick;

  // Command decode
  logic              accept;
  logic [WIDE_W-1:0] fi_wide;
  logic              fi_ok;
  logic [IDX_W-1:0]  fi;
  logic              emit_load;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign fi_wide   = WIDE_W'(cmd.frame_index);
  assign fi_ok     = fi_wide < WIDE_W'(FRAME_COUNT);
  assign fi        = fi_wide[IDX_W-1:0];

  assign pos_next  = (pos == LAST_IDX) ? '0 : pos + 1'b1;
  assign emit_load = (state == S_EMIT) && (!out_valid || rsp.ready);
  assign vict_wide = WIDE_W'(vict);

  // Aging counters, one frame read per cycle; never-written entries read as zero
  assign age_we = (state == S_AGE) && eval_v;

  pvs_ram #(
    .WIDTH (AGE_BITS),
    .DEPTH (FRAME_COUNT)
  ) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (idx_d),
    .wdata (age_aged),
    .raddr (cnt),
    .rdata (ram_q)
  );

  assign age_cur = age_valid[idx_d] ? ram_q : '0;

  pvs_age_alu #(
    .AGE_BITS (AGE_BITS)
  ) u_age_alu (
    .age_in     (age_cur),
    .referenced (refd[idx_d]),
    .best_age   (low),
    .best_valid (lru_found),
    .age_next   (age_aged),
    .is_lower   (age_lower)
  );

  // Tracker updates for the frame under evaluation
  always_comb begin
    idx_wide     = WIDE_W'(idx_d);
    unprot       = !prot[idx_d];
    is_free      = unprot && !mapped[idx_d];
    coin         = (idx_wide < WIDE_W'(pvs_pkg::RANDOM_W)) &&
                   coins[idx_wide[pvs_pkg::COIN_SEL_W-1:0]];
    any_n        = any_found || unprot;
    last_n       = unprot ? idx_d : last_idx;
    coin_found_n = coin_found || (unprot && coin);
    coin_idx_n   = (unprot && coin && !coin_found) ? idx_d : coin_idx;
    take_lru     = unprot && age_lower;
    lru_found_n  = lru_found || take_lru;
    best_n       = take_lru ? idx_d : best_idx;
    low_n        = take_lru ? age_cur : low;
    rand_pick    = coin_found_n ? coin_idx_n : last_n;
  end

  // Sequencer and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prot      <= '0;
      mapped    <= '0;
      refd      <= '0;
      age_valid <= '0;
      mode      <= pvs_pkg::MODE_RANDOM;
      hand      <= '0;
      iss       <= 1'b0;
      eval_v    <= 1'b0;
      cnt       <= '0;
      any_found <= 1'b0;
      coin_found <= 1'b0;
      lru_found <= 1'b0;
      vict_oom  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode <= cfg_wr_data;
      end

      // Frame walk shared by the victim scan and the aging tick
      if (state == S_SCAN || state == S_AGE) begin
        eval_v <= iss;
        idx_d  <= cnt;
        if (iss) begin
          if (cnt == LAST_IDX) begin
            iss <= 1'b0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            coins <= cmd.random_bits;
            unique case (pvs_pkg::op_t'(cmd.operation))
              pvs_pkg::OP_SELECT: begin
                state      <= S_SCAN;
                cnt        <= '0;
                iss        <= 1'b1;
                eval_v     <= 1'b0;
                any_found  <= 1'b0;
                coin_found <= 1'b0;
                lru_found  <= 1'b0;
              end
              pvs_pkg::OP_AGE_TICK: begin
                state  <= S_AGE;
                cnt    <= '0;
                iss    <= 1'b1;
                eval_v <= 1'b0;
              end
              pvs_pkg::OP_MARK_REF: begin
                if (fi_ok) begin
                  refd[fi] <= 1'b1;
                end
              end
              pvs_pkg::OP_SET_FLAGS: begin
                if (fi_ok) begin
                  mapped[fi] <= cmd.mapped_flag;
                  prot[fi]   <= cmd.protected_flag;
                end
              end
            endcase
          end
        end

        S_SCAN: begin
          if (eval_v) begin
            if (is_free) begin
              // free frame wins at once, hand untouched; walk flags are
              // reloaded by the next scan or aging tick
              vict     <= idx_d;
              vict_oom <= 1'b0;
              state    <= S_EMIT;
            end else begin
              any_found  <= any_n;
              last_idx   <= last_n;
              coin_found <= coin_found_n;
              coin_idx   <= coin_idx_n;
              lru_found  <= lru_found_n;
              best_idx   <= best_n;
              low        <= low_n;
              if (idx_d == LAST_IDX) begin
                if (!any_n) begin
                  vict     <= '0;
                  vict_oom <= 1'b1;
                  state    <= S_EMIT;
                end else begin
                  vict_oom <= 1'b0;
                  unique case (mode)
                    pvs_pkg::MODE_CLOCK: begin
                      pos   <= hand;
                      state <= S_CLOCK;
                    end
                    pvs_pkg::MODE_LRU: begin
                      vict  <= best_n;
                      hand  <= best_n;
                      state <= S_EMIT;
                    end
                    default: begin
                      vict  <= rand_pick;
                      state <= S_EMIT;
                    end
                  endcase
                end
              end
            end
          end
        end

        S_AGE: begin
          if (eval_v) begin
            refd[idx_d]      <= 1'b0;
            age_valid[idx_d] <= 1'b1;
            if (idx_d == LAST_IDX) begin
              state <= S_IDLE;
            end
          end
        end

        // Second-chance sweep; an unprotected frame is known to exist
        S_CLOCK: begin
          pos <= pos_next;
          if (!prot[pos]) begin
            if (refd[pos]) begin
              refd[pos] <= 1'b0;
            end else begin
              vict  <= pos;
              hand  <= pos_next;
              state <= S_EMIT;
            end
          end
        end

        S_EMIT: begin
          if (emit_load) begin
            state <= S_IDLE;
            if (!vict_oom) begin
              mapped[vict] <= 1'b0;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_frame      <= vict_wide[pvs_pkg::FRAME_W-1:0];
      out_was_mapped <= !vict_oom && mapped[vict];
      out_oom        <= vict_oom;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.victim_frame      = out_frame;
  assign rsp.victim_was_mapped = out_was_mapped;
  assign rsp.out_of_memory     = out_oom;

`ifndef NO_ASSERTIONS
  // Out of memory carries no victim
  a_oom_payload: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.out_of_memory) |-> (rsp.victim_frame == '0 && !rsp.victim_was_mapped))
    else $error("out of memory result carries a victim");

  // Clock hand always names a real frame
  a_hand_range: assert property (@(posedge clk) disable iff (rst)
    hand <= LAST_IDX)
    else $error("clock hand out of range");

  // A chosen victim is never protected
  a_victim_unprot: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !vict_oom) |-> !prot[vict])
    else $error("protected frame chosen as victim");

  // Delivered victim ends up unmapped
  a_victim_unmapped: assert property (@(posedge clk) disable iff (rst)
    (emit_load && !vict_oom) |=> !mapped[$past(vict)])
    else $error("victim still mapped after delivery");
`endif

endmodule
